@@ rtl/fhj_pkg.sv @@
// ----------------------------------------------------------------------------
// fhj_pkg
// Shared types and constants of the filtered hash join priority counter:
// transaction payloads, slot layout, codes and sequencer states.
// ----------------------------------------------------------------------------
package fhj_pkg;

	// Default sizes
	localparam int TABLE_DEPTH = 4096;
	localparam int PRIO_BINS   = 5;

	// Field widths
	localparam int KIND_W    = 2;
	localparam int KEY_W     = 31;
	localparam int DATE_W    = 27;
	localparam int PRIO_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int IDX_W     = 3;
	localparam int COUNT_W   = 32;
	localparam int CFG_IDX_W = 1;

	// Home slot reduction: reciprocal multiply, subtract, final correction
	localparam int MOD_STEPS = 3;
	localparam int MOD_CNT_W = 2;

	// Register reset values
	localparam logic [DATE_W-1:0] DATE_LOW_RST  = 27'd19930701;
	localparam logic [DATE_W-1:0] DATE_HIGH_RST = 27'd19931001;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DATE_LOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATE_HIGH = 1'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_PROBE  = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SKIP = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_SCAN,
		S_EMIT,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  order_key;
		logic [DATE_W-1:0] order_date;
		logic [PRIO_W-1:0] order_priority;
		logic [DATE_W-1:0] commit_date;
		logic [DATE_W-1:0] receipt_date;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                matched;
		logic [IDX_W-1:0]    count_index;
		logic [COUNT_W-1:0]  count_value;
		logic                last;
	} out_item_t;

	// One hash table slot
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	// Counter bank command
	typedef struct packed {
		logic             inc;
		logic [IDX_W-1:0] bin;
	} count_cmd_t;

endpackage

@@ rtl/filtered_hash_join_priority_count.sv @@
// ----------------------------------------------------------------------------
// filtered_hash_join_priority_count
// Hash join of order items against line items with per-priority counting.
//
// Input transactions (in_valid/in_ready, in_data) carry one item: an order
// insert, a line item probe or a report request. Output transactions
// (out_valid/out_ready, out_data) carry results through one output register;
// inserts and probes give one result, a report gives PRIO_BINS results
// with last set on the final one. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes the order date window at any time.
//
// After reset the table is swept empty, one slot a cycle, all TABLE_DEPTH
// slots (4096 by default), with in_ready low. An insert or probe then walks
// past occupied slots one at a time through the single key comparator, and
// no new item is accepted until its result is issued; with a table depth
// that is not a power of two, the home slot reduction comes before the walk.
// A stalled receiver holds the result in the output register and the
// sequencer waits.
// ----------------------------------------------------------------------------
module filtered_hash_join_priority_count #(
	parameter int TABLE_DEPTH = fhj_pkg::TABLE_DEPTH,
	parameter int PRIO_BINS   = fhj_pkg::PRIO_BINS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fhj_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fhj_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fhj_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fhj_pkg::DATE_W-1:0]      cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [fhj_pkg::DATE_W-1:0]  date_low_q;
	logic [fhj_pkg::DATE_W-1:0]  date_high_q;
	logic                        out_valid_q;
	fhj_pkg::out_item_t          out_data_q;
	logic                        out_free;
	logic                        res_valid;
	fhj_pkg::out_item_t          res_data;
	logic                        tbl_we;
	logic [AW-1:0]               tbl_waddr;
	fhj_pkg::slot_t              tbl_wdata;
	logic [AW-1:0]               tbl_raddr;
	fhj_pkg::slot_t              tbl_rdata;
	fhj_pkg::count_cmd_t         cnt_cmd;
	logic [fhj_pkg::IDX_W-1:0]   cnt_bin;
	logic [fhj_pkg::COUNT_W-1:0] cnt_value;

	// Configuration registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_low_q  <= fhj_pkg::DATE_LOW_RST;
			date_high_q <= fhj_pkg::DATE_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fhj_pkg::CFG_DATE_LOW:  date_low_q  <= cfg_data;
				fhj_pkg::CFG_DATE_HIGH: date_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Output register: load a result, drop it when taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	fhj_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PRIO_BINS   (PRIO_BINS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.date_low  (date_low_q),
		.date_high (date_high_q),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata),
		.cnt_cmd   (cnt_cmd),
		.cnt_bin   (cnt_bin),
		.cnt_value (cnt_value),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	fhj_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	fhj_counts #(
		.PRIO_BINS (PRIO_BINS)
	) u_counts (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cnt_cmd),
		.rd_bin   (cnt_bin),
		.rd_value (cnt_value)
	);

endmodule

@@ rtl/fhj_table.sv @@
// ----------------------------------------------------------------------------
// fhj_table
// Hash table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fhj_table #(
	parameter int TABLE_DEPTH = fhj_pkg::TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
	input  fhj_pkg::slot_t                 wdata,
	input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
	output fhj_pkg::slot_t                 rdata
);

	fhj_pkg::slot_t mem [TABLE_DEPTH];

	// Write slot
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read slot, data valid in the following cycle
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/fhj_counts.sv @@
// ----------------------------------------------------------------------------
// fhj_counts
// Per-priority match counters, saturating, with one read port for reports.
// ----------------------------------------------------------------------------
module fhj_counts #(
	parameter int PRIO_BINS = fhj_pkg::PRIO_BINS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fhj_pkg::count_cmd_t            cmd,
	input  logic [fhj_pkg::IDX_W-1:0]      rd_bin,
	output logic [fhj_pkg::COUNT_W-1:0]    rd_value
);

	localparam int BW = (PRIO_BINS > 1) ? $clog2(PRIO_BINS) : 1;

	logic [fhj_pkg::COUNT_W-1:0] cnt_q [PRIO_BINS];
	logic [BW-1:0]               inc_bin;
	logic [BW-1:0]               rd_sel;

	assign inc_bin = cmd.bin[BW-1:0];
	assign rd_sel  = rd_bin[BW-1:0];

	// Advance the addressed counter, hold at maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIO_BINS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.inc && (cnt_q[inc_bin] != '1)) begin
			cnt_q[inc_bin] <= cnt_q[inc_bin] + 1'b1;
		end
	end

	assign rd_value = cnt_q[rd_sel];

endmodule

@@ rtl/fhj_seq.sv @@
// ----------------------------------------------------------------------------
// fhj_seq
// Item sequencer: filters items, reduces the key to a home slot, walks the
// table one slot per cycle through a single key comparator, and issues
// results one at a time.
// ----------------------------------------------------------------------------
module fhj_seq #(
	parameter int TABLE_DEPTH = fhj_pkg::TABLE_DEPTH,
	parameter int PRIO_BINS   = fhj_pkg::PRIO_BINS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transactions
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fhj_pkg::in_item_t              in_data,
	// configuration
	input  logic [fhj_pkg::DATE_W-1:0]     date_low,
	input  logic [fhj_pkg::DATE_W-1:0]     date_high,
	// table port
	output logic                           tbl_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] tbl_waddr,
	output fhj_pkg::slot_t                 tbl_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] tbl_raddr,
	input  fhj_pkg::slot_t                 tbl_rdata,
	// counter bank
	output fhj_pkg::count_cmd_t            cnt_cmd,
	output logic [fhj_pkg::IDX_W-1:0]      cnt_bin,
	input  logic [fhj_pkg::COUNT_W-1:0]    cnt_value,
	// result load into the output register
	input  logic                           out_free,
	output logic                           res_valid,
	output fhj_pkg::out_item_t             res_data
);

	localparam int  AW   = $clog2(TABLE_DEPTH);
	localparam bit  POW2 = ((1 << AW) == TABLE_DEPTH);
	localparam logic [AW-1:0]              LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [AW:0]                DEPTH_V   = (AW + 1)'(TABLE_DEPTH);
	localparam logic [fhj_pkg::IDX_W-1:0]  LAST_BIN  = fhj_pkg::IDX_W'(PRIO_BINS - 1);
	// floor(2^KEY_W / depth): the quotient estimate is short by at most one
	localparam logic [31:0]                RECIP     =
		32'((64'd1 << fhj_pkg::KEY_W) / TABLE_DEPTH);

	fhj_pkg::state_t  state_q, state_d;

	fhj_pkg::kind_t                  kind_q;
	logic [fhj_pkg::KEY_W-1:0]       key_q;
	logic [fhj_pkg::PRIO_W-1:0]      prio_q;
	fhj_pkg::status_t                stat_q, stat_d;
	logic                            matched_q, matched_d;
	logic [AW-1:0]                   addr_q;
	logic [AW-1:0]                   step_q;
	logic [AW:0]                     rem_q;
	logic [fhj_pkg::KEY_W-1:0]       quot_q;
	logic [fhj_pkg::MOD_CNT_W-1:0]   mcnt_q;
	logic [fhj_pkg::IDX_W-1:0]       bin_q;

	logic                            accept;
	logic                            date_ok;
	logic                            probe_ok;
	logic                            slot_hit;
	logic                            last_step;
	logic                            prio_ok;
	logic [AW-1:0]                   next_addr;
	logic [fhj_pkg::KEY_W+31:0]      recip_prod;
	logic [fhj_pkg::KEY_W-1:0]       key_diff;
	logic [AW-1:0]                   mod_r;
	logic [fhj_pkg::PRIO_W:0]        prio_x;

	assign accept   = in_valid && in_ready;
	assign date_ok  = (in_data.order_date >= date_low) && (in_data.order_date < date_high);
	assign probe_ok = in_data.commit_date < in_data.receipt_date;

	// Slot compare and walk
	assign slot_hit  = tbl_rdata.valid && (tbl_rdata.key == key_q);
	assign last_step = step_q == LAST_ADDR;
	assign next_addr = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
	assign prio_x    = {1'b0, tbl_rdata.prio};
	assign prio_ok   = (prio_x >= (fhj_pkg::PRIO_W + 1)'(1))
		&& (prio_x <= (fhj_pkg::PRIO_W + 1)'(PRIO_BINS));

	// Home slot reduction: estimate the quotient, subtract, correct once
	assign recip_prod = key_q * RECIP;
	assign key_diff   = key_q - quot_q * fhj_pkg::KEY_W'(TABLE_DEPTH);
	assign mod_r      = (rem_q >= DEPTH_V) ? AW'(rem_q - DEPTH_V) : rem_q[AW-1:0];

	assign cnt_bin = bin_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhj_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = addr_q;
		tbl_wdata = '0;
		tbl_raddr = addr_q;
		cnt_cmd   = '0;
		res_valid = 1'b0;
		res_data  = '0;
		stat_d    = stat_q;
		matched_d = matched_q;
		case (state_q)
			fhj_pkg::S_CLEAR: begin
				// sweep the table, one slot a cycle
				tbl_we = 1'b1;
				if (addr_q == LAST_ADDR) begin
					state_d = fhj_pkg::S_IDLE;
				end
			end
			fhj_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				tbl_raddr = in_data.order_key[AW-1:0];
				stat_d    = fhj_pkg::STAT_SKIP;
				matched_d = 1'b0;
				if (accept) begin
					case (fhj_pkg::kind_t'(in_data.kind))
						fhj_pkg::KIND_INSERT: begin
							if (date_ok) begin
								state_d = POW2 ? fhj_pkg::S_SCAN : fhj_pkg::S_MOD;
							end else begin
								state_d = fhj_pkg::S_EMIT;
							end
						end
						fhj_pkg::KIND_PROBE: begin
							if (probe_ok) begin
								state_d = POW2 ? fhj_pkg::S_SCAN : fhj_pkg::S_MOD;
							end else begin
								state_d = fhj_pkg::S_EMIT;
							end
						end
						fhj_pkg::KIND_REPORT: begin
							state_d = fhj_pkg::S_REPORT;
						end
						default: begin
							state_d = fhj_pkg::S_EMIT;
						end
					endcase
				end
			end
			fhj_pkg::S_MOD: begin
				tbl_raddr = mod_r;
				if (mcnt_q == '0) begin
					state_d = fhj_pkg::S_SCAN;
				end
			end
			fhj_pkg::S_SCAN: begin
				tbl_raddr = next_addr;
				if (!tbl_rdata.valid) begin
					// free slot ends the walk
					state_d = fhj_pkg::S_EMIT;
					if (kind_q == fhj_pkg::KIND_INSERT) begin
						tbl_we          = 1'b1;
						tbl_wdata.valid = 1'b1;
						tbl_wdata.key   = key_q;
						tbl_wdata.prio  = prio_q;
						stat_d          = fhj_pkg::STAT_DONE;
					end else begin
						stat_d = fhj_pkg::STAT_SKIP;
					end
				end else if (slot_hit) begin
					// key found: keep first insert, count probe when priority in range
					state_d = fhj_pkg::S_EMIT;
					if (kind_q == fhj_pkg::KIND_INSERT) begin
						stat_d = fhj_pkg::STAT_DONE;
					end else if (prio_ok) begin
						cnt_cmd.inc = 1'b1;
						cnt_cmd.bin = fhj_pkg::IDX_W'(tbl_rdata.prio - 1'b1);
						stat_d      = fhj_pkg::STAT_DONE;
						matched_d   = 1'b1;
					end else begin
						stat_d = fhj_pkg::STAT_SKIP;
					end
				end else if (last_step) begin
					// every slot walked without a hit
					state_d = fhj_pkg::S_EMIT;
					if (kind_q == fhj_pkg::KIND_INSERT) begin
						stat_d = fhj_pkg::STAT_FULL;
					end else begin
						stat_d = fhj_pkg::STAT_SKIP;
					end
				end
			end
			fhj_pkg::S_EMIT: begin
				res_valid        = out_free;
				res_data.status  = stat_q;
				res_data.matched = matched_q;
				res_data.last    = 1'b1;
				if (out_free) begin
					state_d = fhj_pkg::S_IDLE;
				end
			end
			fhj_pkg::S_REPORT: begin
				res_valid            = out_free;
				res_data.status      = fhj_pkg::STAT_DONE;
				res_data.count_index = bin_q;
				res_data.count_value = cnt_value;
				res_data.last        = bin_q == LAST_BIN;
				if (out_free && (bin_q == LAST_BIN)) begin
					state_d = fhj_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fhj_pkg::S_IDLE;
			end
		endcase
	end

	// Walk address, bin counter and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			bin_q  <= '0;
		end else begin
			case (state_q)
				fhj_pkg::S_CLEAR: begin
					addr_q <= next_addr;
				end
				fhj_pkg::S_IDLE: begin
					if (accept) begin
						addr_q <= in_data.order_key[AW-1:0];
						bin_q  <= '0;
					end
				end
				fhj_pkg::S_MOD: begin
					addr_q <= mod_r;
				end
				fhj_pkg::S_SCAN: begin
					addr_q <= next_addr;
				end
				fhj_pkg::S_REPORT: begin
					if (out_free) begin
						bin_q <= bin_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item payload and walk bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= fhj_pkg::kind_t'(in_data.kind);
			key_q     <= in_data.order_key;
			prio_q    <= in_data.order_priority;
			step_q    <= '0;
			rem_q     <= '0;
			mcnt_q    <= fhj_pkg::MOD_CNT_W'(fhj_pkg::MOD_STEPS - 1);
			stat_q    <= stat_d;
			matched_q <= matched_d;
		end else if (state_q == fhj_pkg::S_MOD) begin
			// quotient estimate, then remainder below twice the depth
			quot_q <= recip_prod[fhj_pkg::KEY_W +: fhj_pkg::KEY_W];
			rem_q  <= key_diff[AW:0];
			mcnt_q <= mcnt_q - 1'b1;
		end else if (state_q == fhj_pkg::S_SCAN) begin
			step_q    <= step_q + 1'b1;
			stat_q    <= stat_d;
			matched_q <= matched_d;
		end
	end

endmodule
